// ===== rtl/tcw_pkg.sv =====
// Shared constants, codes and types of the text console writer.
// No dependencies; every other file of the block imports this package.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_ACCESS,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== rtl/tcw_req_if.sv =====
// Request channel of the text console writer: valid/ready plus one item.
// Depends on tcw_pkg for the character width.
interface tcw_req_if #(
  parameter int RW = 5,
  parameter int CW = 7
);
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CHAR_W-1:0] char_code;
  logic [CHAR_W-1:0] attribute;
  logic [RW-1:0]     read_row;
  logic [CW-1:0]     read_column;

  modport source (output valid, opcode, char_code, attribute, read_row, read_column,
                  input ready);
  modport sink   (input valid, opcode, char_code, attribute, read_row, read_column,
                  output ready);
endinterface

// ===== rtl/tcw_rsp_if.sv =====
// Response channel of the text console writer: valid/ready plus one item.
// Depends on tcw_pkg for the character width.
interface tcw_rsp_if #(
  parameter int RW = 5,
  parameter int CW = 7
);
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [RW-1:0]     cursor_row;
  logic [CW-1:0]     cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attr,
                   output ready);
endinterface

// ===== rtl/tcw_screen_ram.sv =====
// Screen store: single-port synchronous RAM of character/attribute cells.
// Depends on tcw_pkg for the cell width and the control struct.
module tcw_screen_ram #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  tcw_pkg::mem_ctl_t        ctl,
  input  logic [AW-1:0]            addr,
  input  logic [tcw_pkg::CELL_W-1:0] wdata,
  output logic [tcw_pkg::CELL_W-1:0] rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Sequencer of the text console writer: cursor, screen rotation, clearing
// and scrolling sweeps, and access of the screen store. Depends on tcw_pkg.
module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  localparam int RW    = $clog2(ROWS),
  localparam int CW    = $clog2(COLUMNS),
  localparam int TOTAL = ROWS * COLUMNS,
  localparam int AW    = $clog2(TOTAL)
) (
  input  logic                       clk,
  input  logic                       rst,
  tcw_req_if.sink                    req,
  output logic                       fin_valid,
  input  logic                       fin_ready,
  output logic [RW-1:0]              fin_row,
  output logic [CW-1:0]              fin_col,
  output logic [tcw_pkg::CELL_W-1:0] fin_cell,
  output tcw_pkg::mem_ctl_t          mem_ctl,
  output logic [AW-1:0]              mem_addr,
  output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
  input  logic [tcw_pkg::CELL_W-1:0] rd_data
);
  import tcw_pkg::*;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);

  state_t state, state_next;

  // Latched item.
  opcode_t           op;
  logic [CHAR_W-1:0] code;
  logic [CHAR_W-1:0] attr;
  logic [RW-1:0]     rrow;
  logic [CW-1:0]     rcol;

  // Cursor and the physical row that holds logical line 0.
  logic [RW-1:0] cursor_row;
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] top;

  logic [AW-1:0] acc_addr;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] scroll_base;
  logic [CW-1:0] scol;
  logic          wr_cell;
  logic          rd_hit;
  logic          do_scroll;

  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;
  logic [RW:0]   row_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] calc_addr;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic          advance;
  logic          scroll_next;
  logic          print_next;
  logic          in_range;

  // Address and cursor arithmetic of the item being worked on.
  always_comb begin
    row_sel = (op == OP_READ) ? rrow : cursor_row;
    col_sel = (op == OP_READ) ? rcol : cursor_col;
    row_sum = {1'b0, row_sel} + {1'b0, top};
    if (row_sum >= (RW+1)'(ROWS)) begin
      phys_row = RW'(row_sum - (RW+1)'(ROWS));
    end else begin
      phys_row = row_sum[RW-1:0];
    end
    calc_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
    in_range  = ({1'b0, rrow} < (RW+1)'(ROWS)) && ({1'b0, rcol} < (CW+1)'(COLUMNS));

    row_next    = cursor_row;
    col_next    = cursor_col;
    advance     = 1'b0;
    print_next  = 1'b0;
    scroll_next = 1'b0;
    if (op == OP_PUT) begin
      case (code) inside
        CODE_NEWLINE, CODE_RETURN: begin
          advance = 1'b1;
        end
        CODE_BACKSPACE: begin
          if (cursor_col != '0) begin
            col_next = cursor_col - 1'b1;
          end
        end
        default: begin
          print_next = 1'b1;
          if (cursor_col == LAST_COL) begin
            advance = 1'b1;
          end else begin
            col_next = cursor_col + 1'b1;
          end
        end
      endcase
    end
    if (advance) begin
      col_next = '0;
      if (cursor_row == LAST_ROW) begin
        scroll_next = 1'b1;
      end else begin
        row_next = cursor_row + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE:   if (req.valid) state_next = ST_CALC;
      ST_CALC:   state_next = ST_ACCESS;
      ST_ACCESS: state_next = do_scroll ? ST_SCROLL : ST_FINISH;
      ST_SCROLL: if (scol == LAST_COL) state_next = ST_FINISH;
      ST_FINISH: if (fin_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    fin_valid = 1'b0;
    mem_ctl   = '0;
    mem_addr  = acc_addr;
    mem_wdata = {attr, code};
    unique case (state)
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
        mem_addr   = clr_addr;
        mem_wdata  = '0;
      end
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_ACCESS: begin
        mem_ctl.we = wr_cell;
        mem_ctl.re = rd_hit;
      end
      ST_SCROLL: begin
        mem_ctl.we = 1'b1;
        mem_addr   = scroll_base + AW'(scol);
        mem_wdata  = BLANK_CELL;
      end
      ST_FINISH: begin
        fin_valid = 1'b1;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign fin_row  = cursor_row;
  assign fin_col  = cursor_col;
  assign fin_cell = rd_hit ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      cursor_row <= '0;
      cursor_col <= '0;
      top        <= '0;
      clr_addr   <= '0;
      rd_hit     <= 1'b0;
      wr_cell    <= 1'b0;
      do_scroll  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        ST_IDLE: begin
          if (req.valid) begin
            op   <= opcode_t'(req.opcode);
            code <= req.char_code;
            attr <= req.attribute;
            rrow <= req.read_row;
            rcol <= req.read_column;
          end
        end
        ST_CALC: begin
          acc_addr   <= calc_addr;
          rd_hit     <= (op == OP_READ) && in_range;
          wr_cell    <= print_next;
          do_scroll  <= scroll_next;
          cursor_row <= row_next;
          cursor_col <= col_next;
        end
        ST_ACCESS: begin
          // The row at the top of the screen becomes the new bottom line.
          scroll_base <= AW'(top) * AW'(COLUMNS);
          scol        <= '0;
        end
        ST_SCROLL: begin
          scol <= scol + 1'b1;
          if (scol == LAST_COL) begin
            top <= (top == LAST_ROW) ? '0 : top + 1'b1;
          end
        end
        default: begin
          wr_cell <= wr_cell;
        end
      endcase
    end
  end

  a_cursor_row_range: assert property (@(posedge clk) disable iff (rst)
    cursor_row <= LAST_ROW && cursor_col <= LAST_COL)
    else $error("cursor outside the screen");

  a_top_range: assert property (@(posedge clk) disable iff (rst)
    top <= LAST_ROW)
    else $error("screen rotation outside the screen");

  a_single_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.we && mem_ctl.re))
    else $error("read and write of the screen store in one cycle");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCROLL |-> cursor_row == LAST_ROW && cursor_col == '0)
    else $error("scroll with the cursor away from the last line start");

  a_accept_calc: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_CALC && !fin_valid)
    else $error("accepted item did not start processing");

endmodule

// ===== rtl/text_console_writer_core.sv =====
// Character-cell text screen engine. Each request item is a put of one character at the
// cursor (newline, carriage return and backspace move the cursor) or a read of one cell; each
// returns one response item with the cursor and, for a read, the stored cell. An accepted
// item passes the calculate, access and finish states into the output register; finish waits
// while that register is full and not taken, and no new item is accepted before finish is left.
// A put that runs past the last line also blanks the new bottom line cell by cell in a scroll
// state, because the screen store has one port. Scrolling itself rotates the row mapping and
// moves no cells. After reset the block clears the store, all ROWS*COLUMNS cells, and accepts
// no item until the clearing ends. The response register lets a new item be taken while a
// finished response waits. Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_ctrl, tcw_screen_ram.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input logic      clk,
  input logic      rst,
  tcw_req_if.sink  req,
  tcw_rsp_if.source rsp
);
  import tcw_pkg::*;

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int TOTAL = ROWS * COLUMNS;
  localparam int AW    = $clog2(TOTAL);

  logic              fin_valid;
  logic              fin_ready;
  logic [RW-1:0]     fin_row;
  logic [CW-1:0]     fin_col;
  logic [CELL_W-1:0] fin_cell;
  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] rd_data;
  logic              out_valid;

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_row   (fin_row),
    .fin_col   (fin_col),
    .fin_cell  (fin_cell),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .rd_data   (rd_data)
  );

  tcw_screen_ram #(
    .DEPTH (TOTAL)
  ) u_ram (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (rd_data)
  );

  assign fin_ready = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_ready) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      rsp.cursor_row <= fin_row;
      rsp.cursor_col <= fin_col;
      rsp.cell_char  <= fin_cell[CHAR_W-1:0];
      rsp.cell_attr  <= fin_cell[CELL_W-1:CHAR_W];
    end
  end

endmodule
